[hdl/wom_pkg.sv]
// shared types and constants for the wavetable oscillator mixer
// sine quarter-wave table is built here at elaboration
// no dependencies
package wom_pkg;

  localparam int TABLE_SIZE      = 1024;
  localparam int TABLE_LOG2      = 10;
  localparam int QUARTER         = TABLE_SIZE / 4;
  localparam int INDEX_BITS      = 10;
  localparam int PHASE_FRAC_BITS = 22;
  localparam int PHASE_BITS      = INDEX_BITS + PHASE_FRAC_BITS;
  localparam int SAMPLE_BITS     = 16;
  localparam int GAIN_BITS       = 16;
  localparam int GAIN_FRAC_BITS  = 14;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_BITS       = 2;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int CFG_DATA_BITS   = 32;

  localparam logic [CFG_INDEX_BITS-1:0] REG_ENABLE   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEP     = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WAVEFORM = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEREO   = 3'd4;

  localparam logic [PHASE_BITS-1:0] STEP_RESET = 32'd19685267;
  localparam logic [GAIN_BITS-1:0]  GAIN_RESET = 16'd16384;

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SAW    = 2'd1,
    WAVE_TRI    = 2'd2,
    WAVE_SQUARE = 2'd3
  } wave_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic [INDEX_BITS-1:0]         idx;
    logic [PHASE_FRAC_BITS-1:0]    frac;
    wave_t                         waveform;
    logic [GAIN_BITS-1:0]          gain;
    logic                          stereo;
    logic                          en;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam int unsigned SIN_DIV [1:6] = '{6, 20, 42, 72, 110, 156};

  typedef logic signed [SAMPLE_BITS-1:0] sine_tab_t [0:QUARTER];

  // round(sin(2*pi*q/N) * 2^15), q30 taylor series of degree 13
  function automatic logic signed [SAMPLE_BITS-1:0] quarter_sine(int unsigned q);
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    longint unsigned r;
    int              k;
    x = (64'(q) * 64'd2 * PI_Q30) >> TABLE_LOG2;
    term = x;
    sum = signed'(x);
    for (k = 1; k <= 6; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / SIN_DIV[k];
      if (k[0]) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = (unsigned'(sum) * 64'd32768 + 64'd536870912) >> 30;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return SAMPLE_BITS'(r);
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t t;
    int        q;
    for (q = 0; q <= QUARTER; q++) begin
      t[q] = quarter_sine(q);
    end
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

endpackage

[hdl/wom_front.sv]
// front end: configuration registers, phase accumulator, job build
// depends on wom_pkg
module wom_front import wom_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] mix_left,
  input  logic signed [SAMPLE_BITS-1:0] mix_right,
  input  q_status_t                     q_status,
  output logic                          push,
  output job_t                          push_job
);

  logic                  enable;
  logic [PHASE_BITS-1:0] phase_step;
  wave_t                 waveform;
  logic [GAIN_BITS-1:0]  gain;
  logic                  stereo;
  logic [PHASE_BITS-1:0] phase;

  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  always_comb begin
    push_job.left     = mix_left;
    push_job.right    = mix_right;
    push_job.idx      = phase[PHASE_BITS-1:PHASE_FRAC_BITS];
    push_job.frac     = phase[PHASE_FRAC_BITS-1:0];
    push_job.waveform = waveform;
    push_job.gain     = gain;
    push_job.stereo   = stereo;
    push_job.en       = enable;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b0;
      phase_step <= STEP_RESET;
      waveform   <= WAVE_SINE;
      gain       <= GAIN_RESET;
      stereo     <= 1'b0;
      phase      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE: enable <= cfg_data[0];
        REG_STEP: begin
          phase_step <= cfg_data[PHASE_BITS-1:0];
          phase      <= '0;
        end
        REG_WAVEFORM: begin
          waveform <= wave_t'(cfg_data[1:0]);
          phase    <= '0;
        end
        REG_GAIN:   gain   <= cfg_data[GAIN_BITS-1:0];
        REG_STEREO: stereo <= cfg_data[0];
        default: ;
      endcase
    end else if (push && enable) begin
      phase <= phase + phase_step;
    end
  end

  a_phase_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index == REG_STEP || cfg_index == REG_WAVEFORM) |=> phase == '0)
    else $error("phase not cleared by step or waveform write");

  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    !cfg_we && !(push && enable) |=> $stable(phase))
    else $error("phase moved without an enabled request");

endmodule

[hdl/wom_queue.sv]
// job queue between front end and back end
// depends on wom_pkg
module wom_queue import wom_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output job_t      head,
  output q_status_t q_status
);

  job_t                 mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;

  assign head           = mem[rd_ptr];
  assign q_status.full  = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign q_status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(push && q_status.full) && !(pop && q_status.empty))
    else $error("queue pushed when full or popped when empty");

endmodule

[hdl/wom_back.sv]
// back end: table lookup, interpolation, gain and saturating mix
// depends on wom_pkg for the sine table and job layout
module wom_back import wom_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  q_status_t                     q_status,
  input  job_t                          head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_left,
  output logic signed [SAMPLE_BITS-1:0] out_right
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FETCH = 7'b0000010,
    S_SEL   = 7'b0000100,
    S_LERP  = 7'b0001000,
    S_SUM   = 7'b0010000,
    S_GAIN  = 7'b0100000,
    S_MIX   = 7'b1000000
  } state_t;

  localparam int QADDR_BITS = INDEX_BITS - 1;
  localparam int DIFF_BITS  = SAMPLE_BITS + 1;
  localparam int PROD_BITS  = DIFF_BITS + PHASE_FRAC_BITS + 1;
  localparam int GPROD_BITS = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int G_BITS     = GPROD_BITS - GAIN_FRAC_BITS;
  localparam int MIX_BITS   = G_BITS + 1;
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  state_t state;
  job_t   job;

  logic signed [SAMPLE_BITS-1:0] rom_a;
  logic signed [SAMPLE_BITS-1:0] rom_b;
  logic signed [SAMPLE_BITS-1:0] a_s;
  logic signed [DIFF_BITS-1:0]   diff;
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [SAMPLE_BITS-1:0] s_val;
  logic signed [GPROD_BITS-1:0]  gprod;

  logic [INDEX_BITS-1:0]         idx_b;
  logic [QADDR_BITS-1:0]         qaddr_a;
  logic [QADDR_BITS-1:0]         qaddr_b;
  logic signed [SAMPLE_BITS-1:0] wave_a;
  logic signed [SAMPLE_BITS-1:0] wave_b;
  logic signed [DIFF_BITS+1-1:0] s_sum;
  logic signed [G_BITS-1:0]      g;
  logic signed [MIX_BITS-1:0]    sum_l;
  logic signed [MIX_BITS-1:0]    sum_r;
  logic                          out_load;

  function automatic logic [QADDR_BITS-1:0] quarter_addr(logic [INDEX_BITS-1:0] i);
    logic [QADDR_BITS-1:0] r;
    r = {1'b0, i[INDEX_BITS-3:0]};
    if (i[INDEX_BITS-2]) begin
      return QADDR_BITS'(QUARTER) - r;
    end
    return r;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] wave_value(
    wave_t wf, logic [INDEX_BITS-1:0] i, logic signed [SAMPLE_BITS-1:0] rom);
    logic signed [SAMPLE_BITS+1:0] t;
    t = '0;
    case (i[INDEX_BITS-1:INDEX_BITS-2])
      2'd0:    t = $signed({1'b0, i, 7'b0});
      2'd3:    t = $signed({1'b0, i - 10'd768, 7'b0}) - 18'sd32768;
      default: t = 18'sd32768 - $signed({1'b0, i - 10'd256, 7'b0});
    endcase
    if (t > 18'sd32767) begin
      t = 18'sd32767;
    end
    case (wf)
      WAVE_SINE:   return i[INDEX_BITS-1] ? -rom : rom;
      WAVE_SAW:    return $signed({i, 6'b0});
      WAVE_TRI:    return t[SAMPLE_BITS-1:0];
      WAVE_SQUARE: return i[INDEX_BITS-1] ? S_MIN : S_MAX;
      default:     return rom;
    endcase
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat(logic signed [MIX_BITS-1:0] v);
    if (v > MIX_BITS'(S_MAX)) begin
      return S_MAX;
    end
    if (v < MIX_BITS'(S_MIN)) begin
      return S_MIN;
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

  assign idx_b   = job.idx + 1'b1;
  assign qaddr_a = quarter_addr(job.idx);
  assign qaddr_b = quarter_addr(idx_b);
  assign wave_a  = wave_value(job.waveform, job.idx, rom_a);
  assign wave_b  = wave_value(job.waveform, idx_b, rom_b);
  assign s_sum   = (DIFF_BITS+1)'(a_s) + (DIFF_BITS+1)'(prod >>> PHASE_FRAC_BITS);
  assign g       = G_BITS'(gprod >>> GAIN_FRAC_BITS);
  assign sum_l   = MIX_BITS'(job.left) + MIX_BITS'(g);
  assign sum_r   = MIX_BITS'(job.right) + MIX_BITS'(g);

  assign pop      = (state == S_IDLE) && !q_status.empty;
  assign out_load = (state == S_MIX) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (pop) begin
            state <= head.en ? S_FETCH : S_MIX;
          end
        end
        S_FETCH: state <= S_SEL;
        S_SEL:   state <= S_LERP;
        S_LERP:  state <= S_SUM;
        S_SUM:   state <= S_GAIN;
        S_GAIN:  state <= S_MIX;
        S_MIX: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= head;
    end
    rom_a <= SINE_TAB[qaddr_a];
    rom_b <= SINE_TAB[qaddr_b];
    if (state == S_SEL) begin
      a_s  <= wave_a;
      diff <= DIFF_BITS'(wave_b) - DIFF_BITS'(wave_a);
    end
    if (state == S_LERP) begin
      prod <= diff * $signed({1'b0, job.frac});
    end
    if (state == S_SUM) begin
      s_val <= s_sum[SAMPLE_BITS-1:0];
    end
    if (state == S_GAIN) begin
      gprod <= s_val * $signed({1'b0, job.gain});
    end
    if (out_load) begin
      out_left  <= job.en ? sat(sum_l) : job.left;
      out_right <= (job.en && job.stereo) ? sat(sum_r) : job.right;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_mix_delivers: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && state == S_IDLE)
    else $error("mixed result not presented");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> state == S_IDLE && !q_status.empty)
    else $error("queue popped outside idle");

endmodule

[hdl/wavetable_oscillator_mixer.sv]
// wavetable oscillator mixer: an enabled request runs through the back-end states fetch,
// select, lerp, sum, gain and mix; a disabled one (pass-through) goes from idle to mix
// the back end works on one request at a time, through its sequential lookup/interpolate/
// gain/mix sequence, and pops the next only when idle; a 4-deep queue absorbs bursts
// reset: synchronous, registers return to defaults, phase cleared, queue emptied;
// the sine table is constant, so no fill pass is needed
module wavetable_oscillator_mixer import wom_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] mix_left,
  input  logic signed [SAMPLE_BITS-1:0] mix_right,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_left,
  output logic signed [SAMPLE_BITS-1:0] out_right
);

  q_status_t q_status;
  logic      push;
  logic      pop;
  job_t      push_job;
  job_t      head;

  wom_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mix_left  (mix_left),
    .mix_right (mix_right),
    .q_status  (q_status),
    .push      (push),
    .push_job  (push_job)
  );

  wom_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  wom_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_left  (out_left),
    .out_right (out_right)
  );

endmodule

[tb/wavetable_oscillator_mixer_tb.sv]
// self-checking testbench for the wavetable oscillator mixer: directed and random requests,
// random idling on both channels, and a predictor with its own wave tables and phase
// depends on wom_pkg and wavetable_oscillator_mixer
module wavetable_oscillator_mixer_tb;
  import wom_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint FULL          = 64'sd1 << (SAMPLE_BITS - 1);
  localparam longint unsigned PI30 = 64'd3373259426;
  localparam int LIMIT_CYCLES      = 800000;
  localparam int SETTLE_CYCLES     = 12;
  localparam int HOLD_CYCLES       = 400;
  localparam int ITEM_TARGET       = 1400;
  localparam int PRESSURE_PHASE    = 3;

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = 16'sh8000;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
  } frame_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0]     cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]      cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] mix_left = '0;
  logic signed [SAMPLE_BITS-1:0] mix_right = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;

  wavetable_oscillator_mixer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mix_left  (mix_left),
    .mix_right (mix_right),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_left  (out_left),
    .out_right (out_right)
  );

  // predictor state
  logic signed [SAMPLE_BITS-1:0] wave_tab [0:4*TABLE_SIZE-1];
  logic [PHASE_BITS-1:0]         osc_phase;
  logic                          cfg_on;
  logic [PHASE_BITS-1:0]         cfg_step;
  wave_t                         cfg_wave;
  logic [GAIN_BITS-1:0]          cfg_gain;
  logic                          cfg_stereo;

  frame_t mix_pending [$];
  frame_t mix_due [$];
  frame_t want;

  int mismatches = 0;
  int n_queued = 0;
  int cycle_count = 0;
  int send_gap = 0;
  int send_calm_left = 0;
  bit send_calm = 1'b0;
  int stall_run = 0;
  int recv_calm_left = 0;
  bit recv_calm = 1'b0;
  bit hold_go = 1'b0;
  bit hold_used = 1'b0;
  int hold_left = 0;

  always #5 clk = ~clk;

  function automatic logic signed [SAMPLE_BITS-1:0] sat16(longint v);
    if (v > FULL - 1) begin
      return SAMPLE_BITS'(FULL - 1);
    end
    if (v < -FULL) begin
      return SAMPLE_BITS'(-FULL);
    end
    return SAMPLE_BITS'(v);
  endfunction

  function automatic longint sine_point(int q);
    longint unsigned x;
    longint unsigned term;
    longint          acc;
    longint          r;
    int              k;
    x = (64'(q) * 64'd2 * PI30) / 64'(TABLE_SIZE);
    term = x;
    acc = longint'(x);
    for (k = 1; k <= 6; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    r = (acc * FULL + (64'sd1 << 29)) >>> 30;
    return (r > FULL - 1) ? FULL - 1 : r;
  endfunction

  function automatic void fill_wave_tab();
    int     i;
    int     r;
    int     half;
    longint v;
    half = TABLE_SIZE / 2;
    for (i = 0; i < TABLE_SIZE; i++) begin
      r = i % QUARTER;
      case (i / QUARTER)
        0: v = sine_point(r);
        1: v = sine_point(QUARTER - r);
        2: v = -sine_point(r);
        default: v = -sine_point(QUARTER - r);
      endcase
      wave_tab[int'(WAVE_SINE) * TABLE_SIZE + i] = sat16(v);
      if (i < half) begin
        v = (longint'(i) * FULL) / half;
      end else begin
        v = (longint'(i - TABLE_SIZE) * FULL) / half;
      end
      wave_tab[int'(WAVE_SAW) * TABLE_SIZE + i] = sat16(v);
      if (i < QUARTER) begin
        v = (longint'(i) * FULL) / QUARTER;
      end else if (i < 3 * QUARTER) begin
        v = FULL - (longint'(i - QUARTER) * FULL) / QUARTER;
      end else begin
        v = (longint'(i - 3 * QUARTER) * FULL) / QUARTER - FULL;
      end
      wave_tab[int'(WAVE_TRI) * TABLE_SIZE + i] = sat16(v);
      wave_tab[int'(WAVE_SQUARE) * TABLE_SIZE + i] = sat16((i < half) ? FULL - 1 : -FULL);
    end
  endfunction

  function automatic void model_defaults();
    osc_phase  = '0;
    cfg_on     = 1'b0;
    cfg_step   = STEP_RESET;
    cfg_wave   = WAVE_SINE;
    cfg_gain   = GAIN_RESET;
    cfg_stereo = 1'b0;
  endfunction

  function automatic void model_write(logic [CFG_INDEX_BITS-1:0] idx,
                                      logic [CFG_DATA_BITS-1:0] d);
    case (idx)
      REG_ENABLE: cfg_on = d[0];
      REG_STEP: begin
        cfg_step  = d[PHASE_BITS-1:0];
        osc_phase = '0;
      end
      REG_WAVEFORM: begin
        cfg_wave  = wave_t'(d[1:0]);
        osc_phase = '0;
      end
      REG_GAIN: cfg_gain = d[GAIN_BITS-1:0];
      REG_STEREO: cfg_stereo = d[0];
      default: ;
    endcase
  endfunction

  // oscillator sample mixed into one request, phase advances when enabled
  function automatic frame_t mix_sample(logic signed [SAMPLE_BITS-1:0] l,
                                        logic signed [SAMPLE_BITS-1:0] r);
    frame_t                y;
    logic [INDEX_BITS-1:0] idx;
    logic [INDEX_BITS-1:0] nxt;
    int                    base;
    longint                a;
    longint                b;
    longint                frac;
    longint                s;
    longint                gw;
    longint                g;
    y.left  = l;
    y.right = r;
    if (cfg_on) begin
      idx  = osc_phase[PHASE_BITS-1:PHASE_FRAC_BITS];
      nxt  = idx + 1'b1;
      frac = osc_phase[PHASE_FRAC_BITS-1:0];
      base = int'(cfg_wave) * TABLE_SIZE;
      a    = wave_tab[base + int'(idx)];
      b    = wave_tab[base + int'(nxt)];
      s    = a + (((b - a) * frac) >>> PHASE_FRAC_BITS);
      gw   = cfg_gain;
      g    = (s * gw) >>> GAIN_FRAC_BITS;
      y.left = sat16(longint'(l) + g);
      if (cfg_stereo) begin
        y.right = sat16(longint'(r) + g);
      end
      osc_phase = osc_phase + cfg_step;
    end
    return y;
  endfunction

  function automatic int idle_len(bit calm);
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 88) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      return S_MAX;
    end
    if (r < 16) begin
      return S_MIN;
    end
    if (r < 20) begin
      return '0;
    end
    if (r < 24) begin
      return '1;
    end
    return SAMPLE_BITS'($urandom);
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_step();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return $urandom;
      3: return 32'($urandom_range(0, TABLE_SIZE - 1)) << PHASE_FRAC_BITS;
      default: return $urandom_range(1, 32'h0400_0000);
    endcase
  endfunction

  function automatic logic [GAIN_BITS-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return GAIN_RESET;
      default: return GAIN_BITS'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string what, logic signed [SAMPLE_BITS-1:0] got,
                                 logic signed [SAMPLE_BITS-1:0] wanted);
    if (mismatches < 40) begin
      $display("mismatch at cycle %0d: %s got %0d wanted %0d", cycle_count, what, got,
               wanted);
    end
    mismatches++;
  endtask

  task automatic put_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    model_write(idx, d);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_item(logic signed [SAMPLE_BITS-1:0] l,
                            logic signed [SAMPLE_BITS-1:0] r);
    frame_t f;
    f.left  = l;
    f.right = r;
    mix_pending.push_back(f);
    n_queued++;
  endtask

  task automatic settle();
    while (mix_pending.size() != 0 || in_valid || mix_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("wavetable_oscillator_mixer regression: fail");
      $finish;
    end
  end

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        mix_due.push_back(mix_sample(mix_left, mix_right));
        void'(mix_pending.pop_front());
        send_gap = idle_len(send_calm);
      end
      if (send_calm_left == 0) begin
        send_calm      = ($urandom_range(0, 2) == 0);
        send_calm_left = $urandom_range(20, 200);
      end else begin
        send_calm_left--;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (mix_pending.size() != 0) begin
          in_valid  <= 1'b1;
          mix_left  <= mix_pending[0].left;
          mix_right <= mix_pending[0].right;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, once
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_go && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (mix_due.size() == 0) begin
          report_mismatch("result with nothing outstanding, out_left", out_left, '0);
        end else begin
          want = mix_due.pop_front();
          if (out_left !== want.left) begin
            report_mismatch("out_left", out_left, want.left);
          end
          if (out_right !== want.right) begin
            report_mismatch("out_right", out_right, want.right);
          end
        end
      end
      if (recv_calm_left == 0) begin
        recv_calm      = ($urandom_range(0, 2) == 0);
        recv_calm_left = $urandom_range(20, 200);
      end else begin
        recv_calm_left--;
      end
      if (stall_run != 0) begin
        stall_run--;
      end else begin
        stall_run = idle_len(recv_calm);
      end
      out_stall <= (hold_left != 0) || (stall_run != 0);
    end
  end

  initial begin
    logic [CFG_DATA_BITS-1:0] d;
    int                       r;
    int                       n;
    int                       phase_no;
    fill_wave_tab();
    model_defaults();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // disabled at reset: pass-through
    queue_item(S_MAX, S_MIN);
    queue_item(S_MIN, S_MAX);
    queue_item('0, '1);
    settle();

    // enabled sine at default step and gain, stereo
    put_reg(REG_ENABLE, '1);
    put_reg(REG_STEREO, 32'h0000_0001);
    queue_item(S_MAX, S_MAX);
    queue_item(S_MIN, S_MIN);
    queue_item('0, '0);
    settle();

    // square at full gain, phase held at zero: positive saturation
    put_reg(REG_GAIN, 32'h0000_ffff);
    put_reg(REG_WAVEFORM, {30'h3fff_ffff, WAVE_SQUARE});
    put_reg(REG_STEP, '0);
    queue_item(S_MAX, S_MIN);
    queue_item(S_MIN, S_MAX);
    settle();

    // half-table step: alternates halves, positive and negative saturation in turn
    put_reg(REG_STEP, 32'h8000_0000);
    queue_item(S_MIN, S_MIN);
    queue_item(S_MIN, S_MIN);
    queue_item(S_MIN, S_MIN);
    settle();

    // largest step: last entry interpolating toward the wrapped first one
    put_reg(REG_STEP, '1);
    queue_item(pick_sample(), pick_sample());
    queue_item(pick_sample(), pick_sample());
    queue_item(pick_sample(), pick_sample());
    settle();

    // sawtooth, zero gain, mono, wide data and spare indexes
    put_reg(REG_GAIN, 32'hffff_0000);
    put_reg(REG_WAVEFORM, {30'h3fff_ffff, WAVE_SAW});
    put_reg(REG_STEREO, 32'hffff_fffe);
    for (r = int'(REG_STEREO) + 1; r < (1 << CFG_INDEX_BITS); r++) begin
      put_reg(CFG_INDEX_BITS'(r), $urandom);
    end
    queue_item(S_MAX, S_MIN);
    queue_item(pick_sample(), pick_sample());
    settle();

    put_reg(REG_GAIN, 32'(GAIN_RESET));
    put_reg(REG_WAVEFORM, 32'(WAVE_TRI));
    put_reg(REG_STEP, 32'h0123_4567);
    queue_item(pick_sample(), pick_sample());
    queue_item(pick_sample(), pick_sample());
    queue_item(pick_sample(), pick_sample());
    settle();

    phase_no = 0;
    while (n_queued < ITEM_TARGET) begin
      d = $urandom;
      d[0] = (phase_no == PRESSURE_PHASE) || ($urandom_range(0, 5) != 0);
      put_reg(REG_ENABLE, d);
      if ($urandom_range(0, 3) != 0) begin
        put_reg(REG_STEP, pick_step());
      end
      if ($urandom_range(0, 2) != 0) begin
        put_reg(REG_WAVEFORM, $urandom);
      end
      if ($urandom_range(0, 1) != 0) begin
        d = $urandom;
        d[GAIN_BITS-1:0] = pick_gain();
        put_reg(REG_GAIN, d);
      end
      if ($urandom_range(0, 1) != 0) begin
        put_reg(REG_STEREO, $urandom);
      end
      if ($urandom_range(0, 7) == 0) begin
        put_reg(CFG_INDEX_BITS'($urandom_range(int'(REG_STEREO) + 1,
                                               (1 << CFG_INDEX_BITS) - 1)), $urandom);
      end
      if (phase_no == PRESSURE_PHASE) begin
        hold_go = 1'b1;
      end
      n = $urandom_range(70, 130);
      repeat (n) queue_item(pick_sample(), pick_sample());
      settle();
      phase_no++;
    end

    if (mismatches == 0) begin
      $display("wavetable_oscillator_mixer regression: pass");
    end else begin
      $display("wavetable_oscillator_mixer regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
hdl/wom_pkg.sv
hdl/wom_front.sv
hdl/wom_queue.sv
hdl/wom_back.sv
hdl/wavetable_oscillator_mixer.sv
tb/wavetable_oscillator_mixer_tb.sv
